// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define RMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RMA_ASSERT_ALWAYS(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/rma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_pkg
// Shared widths, codes and types of the ring module allocator.
// ----------------------------------------------------------------------------
package rma_pkg;

  localparam int DIST_W  = 6;
  localparam int OWNER_W = 5;
  localparam int NODE_W  = 6;

  localparam logic [DIST_W-1:0]  UNREACHED = 6'd63;
  localparam logic [OWNER_W-1:0] OWNER_FREE = 5'd0;

  localparam logic MODE_PREP  = 1'b0;
  localparam logic MODE_PICK  = 1'b1;
  localparam logic FIND_ALLOC = 1'b0;
  localparam logic FIND_REL   = 1'b1;

  // Control of the node state memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_dist;
    logic clr_own;
  } mem_ctl_t;

endpackage

// ===== rtl/core/rma_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_in_if / rma_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface rma_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [rma_pkg::OWNER_W-1:0] pile_id;
  logic [rma_pkg::NODE_W-1:0]  start_node;
  logic                       pick_kind;

  modport source (output valid, output mode, output pile_id, output start_node,
                  output pick_kind, input ready);
  modport sink   (input valid, input mode, input pile_id, input start_node,
                  input pick_kind, output ready);
endinterface

interface rma_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [rma_pkg::NODE_W-1:0] picked_node;

  modport source (output valid, output found, output picked_node, input ready);
  modport sink   (input valid, input found, input picked_node, output ready);
endinterface

// ===== rtl/core/rma_state_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_state_mem
// Per-node owner and distance store, one read and one write a cycle.
// Valid bits give reset values: distance unreached, owner free.
// ----------------------------------------------------------------------------
module rma_state_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rma_pkg::mem_ctl_t             ctl,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [rma_pkg::OWNER_W-1:0]   wr_owner,
  input  logic [rma_pkg::DIST_W-1:0]    wr_dist,
  output logic [rma_pkg::OWNER_W-1:0]   rd_owner,
  output logic [rma_pkg::DIST_W-1:0]    rd_dist
);

  localparam int WW = rma_pkg::OWNER_W + rma_pkg::DIST_W;

  logic [WW-1:0]    mem [DEPTH];
  logic [WW-1:0]    rd_word_r;
  logic [DEPTH-1:0] dist_vld_r;
  logic [DEPTH-1:0] own_vld_r;
  logic             rd_dv_r;
  logic             rd_ov_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_owner, wr_dist};
    end
    if (ctl.rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_vld_r <= '0;
      own_vld_r  <= '0;
      rd_dv_r    <= 1'b0;
      rd_ov_r    <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        rd_dv_r <= dist_vld_r[rd_addr];
        rd_ov_r <= own_vld_r[rd_addr];
      end
      if (ctl.clr_dist) begin
        dist_vld_r <= '0;
      end
      if (ctl.clr_own) begin
        own_vld_r <= '0;
      end
      if (ctl.wr_en) begin
        dist_vld_r[wr_addr] <= 1'b1;
        own_vld_r[wr_addr]  <= 1'b1;
      end
    end
  end

  assign rd_owner = rd_ov_r ? rd_word_r[WW-1:rma_pkg::DIST_W] : rma_pkg::OWNER_FREE;
  assign rd_dist  = rd_dv_r ? rd_word_r[rma_pkg::DIST_W-1:0] : rma_pkg::UNREACHED;

endmodule

// ===== rtl/core/rma_queue_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_queue_mem
// Frontier queue of the distance pass: node and distance per entry.
// ----------------------------------------------------------------------------
module rma_queue_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int QW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [QW-1:0] wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [QW-1:0] rd
);

  logic [QW-1:0] mem [DEPTH];
  logic [QW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

// ===== rtl/core/ring_module_allocator.sv =====
`timescale 1ns / 1ps
// Prepare: start-node check, then a dequeue and three neighbour reads per reached node, then report.
// Pick: anchor reduction, node_count state reads, write-back, then report.
// One item in flight; the single state-memory read port sets the pace.
// Reset: distances unreached, all nodes free, node_count = min(32, MAX_NODES even).
// Writing node_count frees all nodes at once and keeps distances.
// ----------------------------------------------------------------------------
// ring_module_allocator
// Lock table and distance pass over a ring with opposite-node links.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_module_allocator #(
  parameter int MAX_NODES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  rma_in_if.sink            in_ch,
  rma_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [5:0]        cfg_wr_data
);

  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(MAX_NODES);
  localparam int XW = ((NW > rma_pkg::NODE_W) ? NW : rma_pkg::NODE_W) + 1;
  localparam int DW = rma_pkg::DIST_W;
  localparam int OW = rma_pkg::OWNER_W;
  localparam int QW = NW + DW;
  localparam int N_MAX_I = MAX_NODES - (MAX_NODES % 2);
  localparam int N_RST_I = (N_MAX_I < 32) ? N_MAX_I : 32;
  localparam logic [NW-1:0] N_MAX = NW'(N_MAX_I);
  localparam logic [NW-1:0] N_RST = NW'(N_RST_I);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PCHK = 4'd1;
  localparam logic [3:0] S_DEQ  = 4'd2;
  localparam logic [3:0] S_DQW  = 4'd3;
  localparam logic [3:0] S_NB   = 4'd4;
  localparam logic [3:0] S_ARED = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_PWR  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]    st_r, st_nxt;
  logic [NW-1:0] n_r;
  logic [OW-1:0] pile_r, pile_nxt;
  logic [rma_pkg::NODE_W-1:0] start_r, start_nxt;
  logic          rel_r, rel_nxt;
  logic [XW-1:0] anchor_r, anchor_nxt;
  logic [NW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] u_r, u_nxt;
  logic [DW-1:0] du_r, du_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [NW-1:0] lp_r, lp_nxt, rp_r, rp_nxt, rdnode_r, rdnode_nxt;
  logic          side_r, side_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] best_r, best_nxt;
  logic [DW-1:0] bestd_r, bestd_nxt;
  logic          out_valid_r, out_found_r, out_load;
  logic [rma_pkg::NODE_W-1:0] out_picked_r;
  logic [XW-1:0] picked_ext;
  logic          in_fire;
  logic          bfs_act;

  rma_pkg::mem_ctl_t ctl;
  logic [AW-1:0] sm_rd_addr, sm_wr_addr;
  logic [OW-1:0] sm_wr_owner, sm_rd_owner;
  logic [DW-1:0] sm_wr_dist, sm_rd_dist;
  logic          q_we, q_re;
  logic [AW-1:0] q_wa, q_ra;
  logic [QW-1:0] q_wd, q_rd;

  logic [NW-1:0] v_node, anc, nl, nr;
  logic          can_pass;
  logic [6:0]    cfg_v;

  function automatic logic [AW-1:0] to_addr(input logic [NW-1:0] nd);
    logic [NW-1:0] t;
    t = nd - 1'b1;
    return t[AW-1:0];
  endfunction

  function automatic logic [NW-1:0] nbr(input logic [NW-1:0] u, input logic [1:0] k,
                                        input logic [NW-1:0] n);
    logic [NW-1:0] half;
    logic [NW-1:0] r;
    half = n >> 1;
    case (k)
      2'd0:    r = (u == NW'(1)) ? n : u - 1'b1;
      2'd1:    r = (u == n) ? NW'(1) : u + 1'b1;
      default: r = (u > half) ? u - half : u + half;
    endcase
    return r;
  endfunction

  rma_state_mem #(.DEPTH(MAX_NODES), .AW(AW)) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_addr  (sm_rd_addr),
    .wr_addr  (sm_wr_addr),
    .wr_owner (sm_wr_owner),
    .wr_dist  (sm_wr_dist),
    .rd_owner (sm_rd_owner),
    .rd_dist  (sm_rd_dist)
  );

  rma_queue_mem #(.DEPTH(MAX_NODES), .AW(AW), .QW(QW)) u_queue (
    .clk (clk),
    .we  (q_we),
    .wa  (q_wa),
    .wd  (q_wd),
    .re  (q_re),
    .ra  (q_ra),
    .rd  (q_rd)
  );

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_v       = {1'b0, cfg_wr_data & 6'h3E};
  assign picked_ext  = XW'(best_r);
  assign bfs_act     = (st_r == S_DEQ || st_r == S_DQW || st_r == S_NB);

  always_comb begin
    st_nxt     = st_r;
    pile_nxt   = pile_r;
    start_nxt  = start_r;
    rel_nxt    = rel_r;
    anchor_nxt = anchor_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    u_nxt      = u_r;
    du_nxt     = du_r;
    k_nxt      = k_r;
    lp_nxt     = lp_r;
    rp_nxt     = rp_r;
    rdnode_nxt = rdnode_r;
    side_nxt   = side_r;
    cnt_nxt    = cnt_r;
    best_nxt   = best_r;
    bestd_nxt  = bestd_r;
    out_load   = 1'b0;
    ctl        = '0;
    ctl.clr_own = cfg_wr_en;
    sm_rd_addr  = '0;
    sm_wr_addr  = '0;
    sm_wr_owner = '0;
    sm_wr_dist  = '0;
    q_we = 1'b0;
    q_wa = '0;
    q_wd = '0;
    q_re = 1'b0;
    q_ra = '0;
    v_node = nbr(u_r, k_r, n_r);
    can_pass = rel_r ? (sm_rd_owner == pile_r)
                     : (sm_rd_owner == rma_pkg::OWNER_FREE || sm_rd_owner == pile_r);
    anc = (anchor_r == '0) ? n_r : NW'(anchor_r);
    nl  = (lp_r == NW'(1)) ? n_r : lp_r - 1'b1;
    nr  = (rp_r == n_r) ? NW'(1) : rp_r + 1'b1;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          pile_nxt  = in_ch.pile_id;
          start_nxt = in_ch.start_node;
          rel_nxt   = in_ch.pick_kind;
          best_nxt  = '0;
          if (in_ch.mode == rma_pkg::MODE_PREP) begin
            ctl.clr_dist = 1'b1;
            if (in_ch.pile_id == '0 || in_ch.start_node == '0 ||
                XW'(in_ch.start_node) > XW'(n_r)) begin
              st_nxt = S_FIN;
            end else begin
              ctl.rd_en  = 1'b1;
              sm_rd_addr = to_addr(NW'(in_ch.start_node));
              st_nxt     = S_PCHK;
            end
          end else if (in_ch.pile_id == '0) begin
            st_nxt = S_FIN;
          end else begin
            anchor_nxt = (in_ch.pick_kind == rma_pkg::FIND_REL)
                         ? XW'(in_ch.start_node) + XW'(n_r >> 1) : XW'(in_ch.start_node);
            st_nxt = S_ARED;
          end
        end
      end
      S_PCHK: begin
        if (sm_rd_owner != rma_pkg::OWNER_FREE && sm_rd_owner != pile_r) begin
          st_nxt = S_FIN;
        end else begin
          ctl.wr_en   = 1'b1;
          sm_wr_addr  = to_addr(NW'(start_r));
          sm_wr_owner = sm_rd_owner;
          sm_wr_dist  = '0;
          q_we     = 1'b1;
          q_wa     = '0;
          q_wd     = {NW'(start_r), DW'(0)};
          head_nxt = '0;
          tail_nxt = NW'(1);
          st_nxt   = S_DEQ;
        end
      end
      S_DEQ: begin
        if (head_r == tail_r) begin
          st_nxt = S_FIN;
        end else begin
          q_re     = 1'b1;
          q_ra     = head_r[AW-1:0];
          head_nxt = head_r + 1'b1;
          st_nxt   = S_DQW;
        end
      end
      S_DQW: begin
        u_nxt      = q_rd[QW-1:DW];
        du_nxt     = q_rd[DW-1:0];
        k_nxt      = 2'd0;
        ctl.rd_en  = 1'b1;
        sm_rd_addr = to_addr(nbr(q_rd[QW-1:DW], 2'd0, n_r));
        st_nxt     = S_NB;
      end
      S_NB: begin
        if (can_pass && sm_rd_dist == rma_pkg::UNREACHED) begin
          ctl.wr_en   = 1'b1;
          sm_wr_addr  = to_addr(v_node);
          sm_wr_owner = sm_rd_owner;
          sm_wr_dist  = du_r + 1'b1;
          q_we     = 1'b1;
          q_wa     = tail_r[AW-1:0];
          q_wd     = {v_node, DW'(du_r + 1'b1)};
          tail_nxt = tail_r + 1'b1;
        end
        if (k_r == 2'd2) begin
          st_nxt = S_DEQ;
        end else begin
          k_nxt      = k_r + 1'b1;
          ctl.rd_en  = 1'b1;
          sm_rd_addr = to_addr(nbr(u_r, k_r + 1'b1, n_r));
        end
      end
      S_ARED: begin
        // reduce the anchor into 1..node_count, one subtract per cycle
        if (anchor_r > XW'(n_r)) begin
          anchor_nxt = anchor_r - XW'(n_r);
        end else begin
          ctl.rd_en  = 1'b1;
          sm_rd_addr = to_addr(anc);
          rdnode_nxt = anc;
          lp_nxt     = anc;
          rp_nxt     = anc;
          side_nxt   = 1'b0;
          cnt_nxt    = NW'(1);
          st_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sm_rd_dist != rma_pkg::UNREACHED) begin
          if (rel_r) begin
            if (sm_rd_owner == pile_r && (best_r == '0 || sm_rd_dist > bestd_r)) begin
              best_nxt  = rdnode_r;
              bestd_nxt = sm_rd_dist;
            end
          end else if (best_r == '0 || sm_rd_dist < bestd_r) begin
            best_nxt  = rdnode_r;
            bestd_nxt = sm_rd_dist;
          end
        end
        if (cnt_r == n_r) begin
          st_nxt = S_PWR;
        end else begin
          // alternate sides: left first, then right
          ctl.rd_en = 1'b1;
          if (!side_r) begin
            lp_nxt     = nl;
            rdnode_nxt = nl;
            sm_rd_addr = to_addr(nl);
          end else begin
            rp_nxt     = nr;
            rdnode_nxt = nr;
            sm_rd_addr = to_addr(nr);
          end
          side_nxt = ~side_r;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_PWR: begin
        if (best_r != '0) begin
          ctl.wr_en   = 1'b1;
          sm_wr_addr  = to_addr(best_r);
          sm_wr_owner = rel_r ? rma_pkg::OWNER_FREE : pile_r;
          sm_wr_dist  = rma_pkg::UNREACHED;
        end
        st_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      n_r         <= N_RST;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cfg_wr_en) begin
        if (cfg_v < 7'd4) begin
          n_r <= NW'(4);
        end else if (cfg_v > 7'(N_MAX_I)) begin
          n_r <= N_MAX;
        end else begin
          n_r <= NW'(cfg_v);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pile_r   <= pile_nxt;
    start_r  <= start_nxt;
    rel_r    <= rel_nxt;
    anchor_r <= anchor_nxt;
    u_r      <= u_nxt;
    du_r     <= du_nxt;
    k_r      <= k_nxt;
    lp_r     <= lp_nxt;
    rp_r     <= rp_nxt;
    rdnode_r <= rdnode_nxt;
    side_r   <= side_nxt;
    cnt_r    <= cnt_nxt;
    best_r   <= best_nxt;
    bestd_r  <= bestd_nxt;
    if (out_load) begin
      out_found_r  <= (best_r != '0);
      out_picked_r <= picked_ext[rma_pkg::NODE_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.picked_node = out_picked_r;

  `RMA_ASSERT_NEXT(a_busy_after_accept, in_fire, st_r != S_IDLE, "accepted beat left block idle")
  `RMA_ASSERT_ALWAYS(a_head_le_tail, bfs_act |-> head_r <= tail_r, "queue head passed tail")
  `RMA_ASSERT_ALWAYS(a_tail_bound, (st_r == S_NB) |-> tail_r <= n_r, "queue exceeds ring")

endmodule

// ===== test/rma_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_checker
// Watches the request, result and node count ports of the ring module
// allocator. Keeps its own lock table and distance table, works out the
// result of every accepted request beat and compares it field by field with
// the result beats in order.
// ----------------------------------------------------------------------------
module rma_checker (
  input  logic       clk,
  input  logic       rst_n,
  rma_in_if          in_ch,
  rma_out_if         out_ch,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  output int         pending,
  output int         fail_count
);

  localparam int NODES_MAX = 32;

  typedef struct packed {
    logic                       found;
    logic [rma_pkg::NODE_W-1:0] node;
  } pick_result_t;

  logic [rma_pkg::DIST_W-1:0]  dist_tab  [0:NODES_MAX];
  logic [rma_pkg::OWNER_W-1:0] owner_tab [0:NODES_MAX];
  int                          ring_size;
  pick_result_t                expected_results [$];

  function automatic void clear_dist();
    for (int i = 0; i <= NODES_MAX; i++) dist_tab[i] = rma_pkg::UNREACHED;
  endfunction

  function automatic void run_distance_pass(int pile, int start, logic rel);
    int          bfs [0:NODES_MAX];
    int          head;
    int          tail;
    int          u;
    int          v;
    int          half;
    int          nb [0:2];
    logic        ok;
    head = 0;
    tail = 0;
    half = ring_size / 2;
    clear_dist();
    if (pile == 0 || start < 1 || start > ring_size) return;
    if (owner_tab[start] != rma_pkg::OWNER_FREE && owner_tab[start] != pile) return;
    dist_tab[start] = 0;
    bfs[tail++] = start;
    while (head < tail) begin
      u = bfs[head++];
      nb[0] = (u == 1) ? ring_size : u - 1;
      nb[1] = (u == ring_size) ? 1 : u + 1;
      nb[2] = (u > half) ? u - half : u + half;
      for (int k = 0; k < 3; k++) begin
        v = nb[k];
        ok = rel ? (owner_tab[v] == pile)
                 : (owner_tab[v] == rma_pkg::OWNER_FREE || owner_tab[v] == pile);
        if (ok && dist_tab[v] == rma_pkg::UNREACHED && tail <= NODES_MAX) begin
          dist_tab[v] = (int'(dist_tab[u]) + 1 > 62) ? 6'd62 : dist_tab[u] + 1'b1;
          bfs[tail++] = v;
        end
      end
    end
  endfunction

  function automatic int pick_node(int pile, int start, logic rel);
    int best;
    int anchor;
    int idx;
    int i;
    best = 0;
    anchor = start;
    if (pile == 0) return 0;
    if (rel) anchor = ((start + ring_size / 2 + ring_size - 1) % ring_size) + 1;
    for (int k = 1; k <= ring_size; k++) begin
      idx = anchor + ring_size + ((k % 2) ? k / 2 : -(k / 2));
      i = ((idx - 1) % ring_size) + 1;
      if (dist_tab[i] == rma_pkg::UNREACHED) continue;
      if (rel) begin
        if (owner_tab[i] != pile) continue;
        if (best == 0 || dist_tab[i] > dist_tab[best]) best = i;
      end else begin
        if (best == 0 || dist_tab[i] < dist_tab[best]) best = i;
      end
    end
    if (best != 0) begin
      owner_tab[best] = rel ? rma_pkg::OWNER_FREE : pile[rma_pkg::OWNER_W-1:0];
      dist_tab[best] = rma_pkg::UNREACHED;
    end
    return best;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    pick_result_t exp_r;
    int           got;
    int           v;
    if (!rst_n) begin
      ring_size = NODES_MAX;
      clear_dist();
      for (int i = 0; i <= NODES_MAX; i++) owner_tab[i] = rma_pkg::OWNER_FREE;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        v = cfg_wr_data & 6'h3e;
        ring_size = (v < 4) ? 4 : (v > NODES_MAX) ? NODES_MAX : v;
        for (int i = 0; i <= NODES_MAX; i++) owner_tab[i] = rma_pkg::OWNER_FREE;
      end
      if (in_ch.valid && in_ch.ready) begin
        got = 0;
        if (in_ch.mode == rma_pkg::MODE_PREP)
          run_distance_pass(in_ch.pile_id, in_ch.start_node, in_ch.pick_kind);
        else
          got = pick_node(in_ch.pile_id, in_ch.start_node, in_ch.pick_kind);
        exp_r.found = (got != 0);
        exp_r.node  = got[rma_pkg::NODE_W-1:0];
        expected_results.push_back(exp_r);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: found %0d picked_node %0d",
                 out_ch.found, out_ch.picked_node);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.found !== exp_r.found) begin
            $error("found: expected %0d, actual %0d", exp_r.found, out_ch.found);
            fail_count++;
          end
          if (out_ch.picked_node !== exp_r.node) begin
            $error("picked_node: expected %0d, actual %0d", exp_r.node, out_ch.picked_node);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives request beats into the ring module allocator: directed cases, then
// prepare/pick sequences with random content and some noise, over several
// node counts and idle/stall phases. The checker does all comparison.
// ----------------------------------------------------------------------------
module testbench;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = 6'd0;
  int         pending;
  int         fail_count;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         ring_nodes = 32;

  rma_in_if  in_bus();
  rma_out_if out_bus();

  ring_module_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  rma_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #50ms;
    $display("testbench failed");
    $finish;
  end

  task automatic send_req(logic mode, int pile, int start, logic ft);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= mode;
    in_bus.pile_id    <= pile[rma_pkg::OWNER_W-1:0];
    in_bus.start_node <= start[rma_pkg::NODE_W-1:0];
    in_bus.pick_kind  <= ft;
    @(posedge clk);
    while (!(in_bus.valid && in_bus.ready)) @(posedge clk);
  endtask

  // Drain and let the block settle, then rewrite the node count.
  task automatic set_nodes(int val);
    int v;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val[5:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    v = val & 6'h3e;
    ring_nodes = (v < 4) ? 4 : (v > 32) ? 32 : v;
  endtask

  task automatic random_traffic(int count);
    int   sent;
    int   pile;
    int   start;
    logic ft;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_req(1'($urandom_range(1)), $urandom_range(31), $urandom_range(63),
                 1'($urandom_range(1)));
        sent++;
      end else begin
        pile  = $urandom_range(4) == 0 ? $urandom_range(31, 1) : $urandom_range(4, 1);
        start = $urandom_range(ring_nodes, 1);
        ft    = ($urandom_range(2) == 0);
        send_req(rma_pkg::MODE_PREP, pile, start, ft);
        sent++;
        repeat ($urandom_range(3, 1)) begin
          send_req(rma_pkg::MODE_PICK, pile, start, ft);
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.mode       <= rma_pkg::MODE_PREP;
    in_bus.pile_id    <= '0;
    in_bus.start_node <= '0;
    in_bus.pick_kind  <= rma_pkg::FIND_ALLOC;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: allocate several, release, foreign start, pile zero, bad starts
    send_req(rma_pkg::MODE_PREP, 1, 1, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PICK, 1, 1, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PICK, 1, 1, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PICK, 1, 1, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PREP, 2, 2, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PREP, 1, 32, rma_pkg::FIND_REL);
    send_req(rma_pkg::MODE_PICK, 1, 32, rma_pkg::FIND_REL);
    send_req(rma_pkg::MODE_PICK, 1, 32, rma_pkg::FIND_REL);
    send_req(rma_pkg::MODE_PREP, 0, 5, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PICK, 0, 5, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PREP, 31, 0, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PICK, 31, 0, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PREP, 31, 63, rma_pkg::FIND_REL);
    send_req(rma_pkg::MODE_PICK, 31, 63, rma_pkg::FIND_REL);
    send_req(rma_pkg::MODE_PREP, 16, 17, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PICK, 16, 63, rma_pkg::FIND_ALLOC);
    send_req(rma_pkg::MODE_PICK, 3, 40, rma_pkg::FIND_REL);
    set_nodes(0);
    send_req(rma_pkg::MODE_PREP, 5, 4, rma_pkg::FIND_ALLOC);
    repeat (5) send_req(rma_pkg::MODE_PICK, 5, 4, rma_pkg::FIND_ALLOC);
    set_nodes(63);
    send_req(rma_pkg::MODE_PICK, 5, 4, rma_pkg::FIND_REL);
    set_nodes(7);
    send_req(rma_pkg::MODE_PREP, 2, 6, rma_pkg::FIND_REL);

    gap_pct = 0;  stall_pct = 0;
    random_traffic(290);
    set_nodes(4);
    gap_pct = 62; stall_pct = 0;
    random_traffic(280);
    set_nodes(19);
    gap_pct = 0;  stall_pct = 62;
    random_traffic(290);
    set_nodes(32);
    gap_pct = 31; stall_pct = 31;
    random_traffic(290);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
